### design/sis_pkg.sv
// sis_pkg: shared constants and types for the stable insertion sorter.
// No dependencies; used by sis_cell and stable_insertion_sorter.
package sis_pkg;

  // Number of cells in the sorting chain (capacity of one set)
  localparam int unsigned Depth = 16;
  localparam int unsigned DataW = 32;

  // Sequencer states
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast value this cycle
    logic drain;  // shift every entry one place toward cell 0
  } cell_ctrl_t;

endpackage

### design/stable_insertion_sorter.sv
// stable_insertion_sorter: top level, chain of sis_cell instances plus sequencer.
// Depends on sis_pkg and sis_cell.
//
// Usage: present a value with start_i high; it is taken when busy_o is low, one beat per
// cycle while a set is being loaded. Each value is placed into a sorted row of Depth cells
// in the cycle it is taken (all cells compare against it in parallel). The beat with
// last_in_i set closes the set: from the next cycle busy_o is high and the stored values
// come out on consecutive cycles, ascending, one per cycle, each marked by result_valid_o;
// equal values appear in arrival order. The drain is one shift of the cell row per result.
// The receiver cannot stall: every result is present for exactly one cycle. The final result
// carries last_out_o. Values arriving while all Depth cells are full are discarded and every
// result of that set carries overflow_o. After the final result the block is ready again.
module stable_insertion_sorter
  import sis_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_in_i,
  output logic                    result_valid_o,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_out_o,
  output logic                    overflow_o
);

  state_e     state_q, state_d;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       drain_end;
  logic       ovf_q, ovf_d;

  logic signed [DataW-1:0] cell_val   [Depth];
  logic                    cell_valid [Depth];
  logic                    cell_gt    [Depth];

  // Chain of cells
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] lo_val, hi_val;
    logic                    lo_valid, lo_gt, hi_valid;

    if (i == 0) begin : g_first
      assign lo_val   = '0;
      assign lo_valid = 1'b1;
      assign lo_gt    = 1'b0;
    end else begin : g_mid_lo
      assign lo_val   = cell_val[i-1];
      assign lo_valid = cell_valid[i-1];
      assign lo_gt    = cell_gt[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign hi_val   = '0;
      assign hi_valid = 1'b0;
    end else begin : g_mid_hi
      assign hi_val   = cell_val[i+1];
      assign hi_valid = cell_valid[i+1];
    end

    sis_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_val_i  (value_i),
      .lo_val_i   (lo_val),
      .lo_valid_i (lo_valid),
      .lo_gt_i    (lo_gt),
      .hi_val_i   (hi_val),
      .hi_valid_i (hi_valid),
      .val_o      (cell_val[i]),
      .valid_o    (cell_valid[i]),
      .gt_o       (cell_gt[i])
    );
  end

  assign full      = cell_valid[Depth-1];
  assign accept    = start_i && !busy_o;
  assign drain_end = (state_q == ST_DRAIN) && !cell_valid[1];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (accept && last_in_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cell_valid[1]) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // Outputs and cell commands
  always_comb begin
    busy_o     = 1'b0;
    ctrl.ins   = 1'b0;
    ctrl.drain = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        ctrl.ins = accept && !full;
      end
      ST_DRAIN: begin
        busy_o     = 1'b1;
        ctrl.drain = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  // Overflow flag: set on a dropped beat, cleared after the set's final result
  always_comb begin
    ovf_d = ovf_q;
    if (drain_end) begin
      ovf_d = 1'b0;
    end else if (accept && full) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  // Results come straight off cell 0 during the drain
  assign result_valid_o = (state_q == ST_DRAIN) && cell_valid[0];
  assign sorted_value_o = cell_val[0];
  assign last_out_o     = drain_end;
  assign overflow_o     = ovf_q;

  // Checks
  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside drain");

  a_drain_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_end |=> !cell_valid[0] && !busy_o)
    else $error("cells not empty after final result");

  a_drain_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> cell_valid[0])
    else $error("drain with empty cell 0");

  a_ovf_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && $past(busy_o)) |-> $stable(overflow_o))
    else $error("overflow changed within a set's results");

endmodule

### design/sis_cell.sv
// sis_cell: one storage cell of the insertion chain (value plus valid bit).
// Depends on sis_pkg for widths and the command struct.
module sis_cell
  import sis_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [DataW-1:0] new_val_i,
  // neighbor toward cell 0
  input  logic signed [DataW-1:0] lo_val_i,
  input  logic                    lo_valid_i,
  input  logic                    lo_gt_i,
  // neighbor away from cell 0
  input  logic signed [DataW-1:0] hi_val_i,
  input  logic                    hi_valid_i,
  output logic signed [DataW-1:0] val_o,
  output logic                    valid_o,
  output logic                    gt_o
);

  logic signed [DataW-1:0] val_q, val_d;
  logic                    valid_q, valid_d;
  logic                    take;

  // Strictly greater entries move up, so equal values keep arrival order
  assign gt_o = valid_q && (val_q > new_val_i);

  // Occupied cells above the insertion point and the first free cell load
  assign take = valid_q ? gt_o : lo_valid_i;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.drain) begin
      val_d   = hi_val_i;
      valid_d = hi_valid_i;
    end else if (ctrl_i.ins && take) begin
      val_d   = (lo_valid_i && lo_gt_i) ? lo_val_i : new_val_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

### dv/stable_insertion_sorter_test.sv
`timescale 1ns / 100ps
// stable_insertion_sorter_test: self-checking testbench for the stable insertion sorter.
// Uses sis_pkg for Depth and DataW; a scoreboard class predicts every sorted set.
module stable_insertion_sorter_test;
  import sis_pkg::*;

  typedef logic signed [DataW-1:0] elem_t;

  typedef struct {
    elem_t value;
    logic  last;
    logic  ovf;
  } sorted_beat_t;

  localparam elem_t MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam elem_t MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned DrainCycles = 2 * Depth + 4;

  // Predicts each set: a sorted row, the dropped flag, and the results awaited on the outputs
  class sorted_set_scoreboard;
    elem_t        sorted_row[$];
    logic         dropped;
    sorted_beat_t awaited[$];
    int unsigned  mismatches;

    function new();
      dropped = 1'b0;
      mismatches = 0;
    endfunction

    // Accepted input beat: insert above all equal entries, emit the row on last
    function void take_value(elem_t v, logic last);
      int pos;
      sorted_beat_t b;
      if (sorted_row.size() >= Depth) begin
        dropped = 1'b1;
      end else begin
        pos = sorted_row.size();
        while (pos > 0 && sorted_row[pos-1] > v) pos--;
        sorted_row.insert(pos, v);
      end
      if (last) begin
        foreach (sorted_row[k]) begin
          b.value = sorted_row[k];
          b.last  = (k == sorted_row.size() - 1);
          b.ovf   = dropped;
          awaited.push_back(b);
        end
        sorted_row.delete();
        dropped = 1'b0;
      end
    endfunction

    // Result beat: compare against the oldest awaited result
    function void check_result(elem_t v, logic last, logic ovf);
      sorted_beat_t b;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: value %0d last %0b overflow %0b",
                   $realtime, v, last, ovf);
        return;
      end
      b = awaited.pop_front();
      if (b.value !== v || b.last !== last || b.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                   $realtime, b.value, b.last, b.ovf, v, last, ovf);
      end
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  elem_t value_i;
  logic  last_in_i;
  logic  result_valid_o;
  elem_t sorted_value_o;
  logic  last_out_o;
  logic  overflow_o;

  sorted_set_scoreboard sorter_model;
  int unsigned idle_pct;

  stable_insertion_sorter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .last_in_i      (last_in_i),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("stable_insertion_sorter test failed");
    $finish;
  end

  // Result monitor; X on the strobe counts as a result too
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o !== 1'b0)
      sorter_model.check_result(sorted_value_o, last_out_o, overflow_o);
  end

  // Mix of full-range, duplicate-heavy and extreme values
  function automatic elem_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: pick_value = elem_t'($urandom);
      5, 6, 7:       pick_value = elem_t'($urandom_range(0, 8)) - 4;
      8:             pick_value = MinVal + elem_t'($urandom_range(0, 2));
      default:       pick_value = MaxVal - elem_t'($urandom_range(0, 2));
    endcase
  endfunction

  // One input beat; entered and left at a falling edge
  task automatic send_value(elem_t v, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i   <= 1'b0;
      value_i   <= elem_t'($urandom);
      last_in_i <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    start_i   <= 1'b1;
    value_i   <= v;
    last_in_i <= last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sorter_model.take_value(v, last);
    @(negedge clk_i);
  endtask

  task automatic send_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_value(pick_value(), i == n - 1);
  endtask

  // Hold the sender off until every awaited result has come out
  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sorter_model.awaited.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    sorter_model = new();
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    value_i   = '0;
    last_in_i = 1'b0;
    idle_pct  = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: single-value set, extremes with duplicates
    send_value(MinVal, 1'b1);
    send_value(MaxVal, 1'b0);
    send_value(MinVal, 1'b0);
    send_value('0, 1'b0);
    send_value(-1, 1'b0);
    send_value(1, 1'b0);
    send_value(MaxVal, 1'b0);
    send_value(MinVal, 1'b1);
    // Descending fill of the whole row, then the closing beat is dropped
    for (int unsigned i = 0; i < Depth; i++) send_value(elem_t'(Depth - 1 - i), 1'b0);
    send_value(-7, 1'b1);
    wait_drained();

    // Random sets: sender idles 22%, then 61%, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 22 : (phase == 1) ? 61 : 0;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if ($urandom_range(0, 7) == 0) n = $urandom_range(Depth, Depth + 6);
        else n = $urandom_range(1, Depth);
        send_set(n);
        sent += n;
      end
      if (phase == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (sorter_model.mismatches == 0 && sorter_model.awaited.size() == 0)
      $display("stable_insertion_sorter test passed");
    else
      $display("stable_insertion_sorter test failed");
    $finish;
  end

endmodule
